// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the keypad classifier rtl
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked check, off while reset is asserted
`define MKPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MKPC_ASSERT_IMP(label, ante, cons, msg) \
    `MKPC_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/mkpc_pkg.sv =====
// shared types and constants for the matrix keypad press classifier
// no dependencies
`default_nettype none

package mkpc_pkg;

    localparam int ROW_W   = 4;
    localparam int SCAN_W  = 8;
    localparam int KEY_W   = 5;
    localparam int COUNT_W = 8;

    localparam logic [ROW_W-1:0]   NO_KEY_ROWS       = 4'hF;
    localparam logic [COUNT_W-1:0] LONG_TICKS_RESET  = 8'd200;
    localparam logic [KEY_W-1:0]   KEY_BASE          = 5'd4;
    localparam logic [KEY_W-1:0]   KEY_LAST          = 5'd19;
    localparam logic [KEY_W-1:0]   KEY_NONE          = 5'd0;

    // one-cold nibble codes, in position order 0 to 3
    localparam logic [3:0] NIB_POS0 = 4'h7;
    localparam logic [3:0] NIB_POS1 = 4'hB;
    localparam logic [3:0] NIB_POS2 = 4'hD;
    localparam logic [3:0] NIB_POS3 = 4'hE;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HELD    = 2'd2,
        PH_LONG    = 2'd3
    } t_phase;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_key_dec;

endpackage

`default_nettype wire

// ===== rtl/mkpc_key_decode.sv =====
// reversed-scan byte to key number decoder, keys 4 to 19
// depends on mkpc_pkg
`default_nettype none

module mkpc_key_decode (
    input  wire logic [mkpc_pkg::SCAN_W-1:0] i_scan,
    output mkpc_pkg::t_key_dec               o_dec
);

    logic [1:0] hi_pos;
    logic [1:0] lo_pos;
    logic       hi_ok;
    logic       lo_ok;

    always_comb begin
        hi_ok  = 1'b1;
        hi_pos = 2'd0;
        unique case (i_scan[7:4])
            mkpc_pkg::NIB_POS0: hi_pos = 2'd0;
            mkpc_pkg::NIB_POS1: hi_pos = 2'd1;
            mkpc_pkg::NIB_POS2: hi_pos = 2'd2;
            mkpc_pkg::NIB_POS3: hi_pos = 2'd3;
            default:            hi_ok  = 1'b0;
        endcase
    end

    always_comb begin
        lo_ok  = 1'b1;
        lo_pos = 2'd0;
        unique case (i_scan[3:0])
            mkpc_pkg::NIB_POS0: lo_pos = 2'd0;
            mkpc_pkg::NIB_POS1: lo_pos = 2'd1;
            mkpc_pkg::NIB_POS2: lo_pos = 2'd2;
            mkpc_pkg::NIB_POS3: lo_pos = 2'd3;
            default:            lo_ok  = 1'b0;
        endcase
    end

    // 4 + 4*hi + lo, formed as KEY_BASE plus the concatenation {hi, lo}
    always_comb begin
        o_dec.valid = hi_ok && lo_ok;
        o_dec.key   = o_dec.valid ? (mkpc_pkg::KEY_BASE + {1'b0, hi_pos, lo_pos})
                                  : mkpc_pkg::KEY_NONE;
    end

endmodule

`default_nettype wire

// ===== rtl/matrix_keypad_press_classifier.sv =====
// top level of the matrix keypad press classifier: phase machine, hold counter, output skid
// depends on mkpc_pkg, mkpc_key_decode and assert_macros.svh
//
// One input word is one scan tick of a 4x4 keypad and gives exactly one output word.
// The phase machine, key decode and hold counter update in the cycle the word is accepted, and
// the result is registered on that edge in the output register, or in the skid entry if the
// output stalls, so a word can be accepted every cycle while s_axis_tready is high. A two-deep
// stage (register plus skid) keeps s_axis_tready registered; it drops only while both are full.
// A release from the held phase reports a short press, a release from the long-held
// phase a long press; every other tick reports event_valid 0 with key_number 0.
// long_press_ticks may be written any time the block is idle and resets to 200.
`default_nettype none
`include "assert_macros.svh"

module matrix_keypad_press_classifier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,   // long_press_ticks
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [3:0] row_sense, [11:4] reverse_scan, [15:12] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [0] event_valid, [5:1] key_number, [7:6] zero
    output logic [0:0]       m_axis_tuser   // [0] long_press
);

    localparam int KW = mkpc_pkg::KEY_W;
    localparam int CW = mkpc_pkg::COUNT_W;

    typedef struct packed {
        logic          ev;
        logic [KW-1:0] key;
        logic          lng;
    } t_result;

    logic [CW-1:0]            r_thresh;
    mkpc_pkg::t_phase         r_phase, n_phase;
    logic [KW-1:0]            r_held_key, n_held_key;
    logic [CW-1:0]            r_hold_count, n_hold_count;
    logic [CW-1:0]            count_inc;
    t_result                  res;
    t_result                  r_out, r_skid;
    logic                     r_out_valid, r_skid_valid;
    logic                     accept;
    logic                     take;
    logic                     down;
    mkpc_pkg::t_key_dec       dec;

    logic [mkpc_pkg::ROW_W-1:0]  row_sense;
    logic [mkpc_pkg::SCAN_W-1:0] reverse_scan;

    assign row_sense    = s_axis_tdata[3:0];
    assign reverse_scan = s_axis_tdata[11:4];
    assign down         = row_sense != mkpc_pkg::NO_KEY_ROWS;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = r_out_valid && m_axis_tready;

    mkpc_key_decode u_decode (
        .i_scan (reverse_scan),
        .o_dec  (dec)
    );

    assign count_inc = r_hold_count + 1'b1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            mkpc_pkg::PH_IDLE: begin
                if (down) n_phase = mkpc_pkg::PH_CONFIRM;
            end
            mkpc_pkg::PH_CONFIRM: begin
                n_phase = (down && dec.valid) ? mkpc_pkg::PH_HELD : mkpc_pkg::PH_IDLE;
            end
            mkpc_pkg::PH_HELD: begin
                if (!down) begin
                    n_phase = mkpc_pkg::PH_IDLE;
                end else if (count_inc >= r_thresh) begin
                    n_phase = mkpc_pkg::PH_LONG;
                end
            end
            mkpc_pkg::PH_LONG: begin
                if (!down) n_phase = mkpc_pkg::PH_IDLE;
            end
            default: n_phase = mkpc_pkg::PH_IDLE;
        endcase
    end

    // data path and result
    always_comb begin
        n_held_key   = r_held_key;
        n_hold_count = r_hold_count;
        res          = '0;
        unique case (r_phase)
            mkpc_pkg::PH_IDLE: ;
            mkpc_pkg::PH_CONFIRM: begin
                if (down && dec.valid) n_held_key = dec.key;
            end
            mkpc_pkg::PH_HELD: begin
                if (down) begin
                    n_hold_count = (count_inc >= r_thresh) ? '0 : count_inc;
                end else begin
                    res.ev       = 1'b1;
                    res.key      = r_held_key;
                    n_hold_count = '0;
                    n_held_key   = mkpc_pkg::KEY_NONE;
                end
            end
            mkpc_pkg::PH_LONG: begin
                if (!down) begin
                    res.ev     = 1'b1;
                    res.key    = r_held_key;
                    res.lng    = 1'b1;
                    n_held_key = mkpc_pkg::KEY_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh     <= mkpc_pkg::LONG_TICKS_RESET;
            r_phase      <= mkpc_pkg::PH_IDLE;
            r_held_key   <= mkpc_pkg::KEY_NONE;
            r_hold_count <= '0;
        end else begin
            if (i_cfg_we) r_thresh <= i_cfg_wdata;
            if (accept) begin
                r_phase      <= n_phase;
                r_held_key   <= n_held_key;
                r_hold_count <= n_hold_count;
            end
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {2'b00, r_out.key, r_out.ev};
    assign m_axis_tuser[0] = r_out.lng;

    `MKPC_ASSERT_IMP(a_long_has_event, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[0],
        "long press flagged without an event")
    `MKPC_ASSERT_IMP(a_event_key_range, m_axis_tvalid && m_axis_tdata[0],
        m_axis_tdata[5:1] >= mkpc_pkg::KEY_BASE && m_axis_tdata[5:1] <= mkpc_pkg::KEY_LAST,
        "event carries a key outside 4 to 19")
    `MKPC_ASSERT_IMP(a_no_event_zero, m_axis_tvalid && !m_axis_tdata[0],
        m_axis_tdata[5:1] == mkpc_pkg::KEY_NONE && !m_axis_tuser[0],
        "non-event word has nonzero key or long flag")
    `MKPC_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid entry full while output register empty")
    `MKPC_ASSERT_IMP(a_count_only_held, r_phase != mkpc_pkg::PH_HELD, r_hold_count == '0,
        "hold counter nonzero outside the held phase")

endmodule

`default_nettype wire
